[hdl/pcst_pkg.sv]
// Shared types, constants and helpers for the PWM compare shadow translator.
`default_nettype none

package pcst_pkg;

    localparam int UNIT_COUNT_DEF = 4;

    // Output index field carried between controller and datapath (up to 16 outputs)
    localparam int SEL_W = 4;

    localparam logic [15:0] PERIOD_RST = 16'd375;

    localparam logic [15:0] CTL_INIT = 16'hC0B1;
    localparam logic [15:0] ACT_INIT = 16'h0042;

    localparam logic [4:0] OFF_CTL    = 5'd0;
    localparam logic [4:0] OFF_CNT    = 5'd8;
    localparam logic [4:0] OFF_PRD    = 5'd10;
    localparam logic [4:0] OFF_CMPCTL = 5'd14;
    localparam logic [4:0] OFF_CMPA   = 5'd18;
    localparam logic [4:0] OFF_CMPB   = 5'd20;
    localparam logic [4:0] OFF_ACTA   = 5'd22;
    localparam logic [4:0] OFF_ACTB   = 5'd24;

    // round(ticks * 80 / 3) == floor((80 * ticks + 1) / 3); saturates above 2457 ticks
    localparam logic [15:0] SCALE_SAT_TICKS = 16'd2457;
    localparam logic [19:0] SCALE_RECIP     = 20'd349526;
    localparam int          SCALE_SHIFT     = 20;

    typedef enum logic [1:0] {
        CMD_INIT   = 2'd0,
        CMD_PERIOD = 2'd1,
        CMD_GATE   = 2'd2,
        CMD_WIDTH  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_GATE_SCAN,
        ST_LOAD,
        ST_MUL,
        ST_EMIT,
        ST_INIT_EMIT
    } state_t;

    typedef enum logic [1:0] {
        SRC_DEFAULT,
        SRC_TICKS,
        SRC_WIDTH,
        SRC_PERIOD
    } src_t;

    typedef enum logic [1:0] {
        LIM_NONE,
        LIM_TICKS,
        LIM_PERIOD
    } lim_t;

    typedef enum logic [1:0] {
        VAL_SCALED,
        VAL_CTL,
        VAL_ACT,
        VAL_ZERO
    } val_t;

    typedef struct packed {
        logic             latch;
        logic             load;
        logic             mul;
        logic             emit;
        logic             init_state;
        logic             store_period;
        logic             store_width;
        logic             store_enable;
        src_t             src;
        lim_t             lim;
        logic [SEL_W-1:0] sel;
        val_t             val;
        logic [4:0]       offset;
        logic [1:0]       unit;
        logic             last;
    } dp_cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic       period_ok;
        logic       width_ok;
        logic [2:0] width_sel;
        logic       width_enabled;
        logic [7:0] gate_mask;
        logic       en;
        logic [2:0] unit_full;
        logic       out_free;
    } dp_status_t;

    function automatic logic [4:0] init_offset(input logic [2:0] k);
        logic [4:0] off;
        unique case (k)
            3'd0:    off = OFF_CTL;
            3'd1:    off = OFF_CMPCTL;
            3'd2:    off = OFF_CNT;
            3'd3:    off = OFF_PRD;
            3'd4:    off = OFF_CMPA;
            3'd5:    off = OFF_CMPB;
            3'd6:    off = OFF_ACTA;
            default: off = OFF_ACTB;
        endcase
        return off;
    endfunction

    function automatic val_t init_value(input logic [2:0] k);
        val_t v;
        unique case (k)
            3'd0:                  v = VAL_CTL;
            3'd1, 3'd2:            v = VAL_ZERO;
            3'd3, 3'd4, 3'd5:      v = VAL_SCALED;
            default:               v = VAL_ACT;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[hdl/pcst_datapath.sv]
// Datapath: command capture, cached state, clamp, tick scaler and output register.
`default_nettype none

module pcst_datapath #(
    parameter int UNIT_COUNT = pcst_pkg::UNIT_COUNT_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [39:0]          s_tdata,
    input  wire logic [1:0]           s_tuser,
    input  wire logic                 cfg_we,
    input  wire logic [15:0]          cfg_wdata,
    input  wire pcst_pkg::dp_cmd_t    cmd_i,
    output pcst_pkg::dp_status_t      status_o,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [23:0]               m_tdata,
    output logic                      m_tlast
);

    localparam int OUTS   = 2 * UNIT_COUNT;
    localparam int OUT_W  = $clog2(OUTS);
    localparam int UIW    = (UNIT_COUNT > 1) ? $clog2(UNIT_COUNT) : 1;
    localparam int GATE_N = (OUTS < 8) ? OUTS : 8;
    localparam logic [7:0] GATE_MASK = 8'((1 << GATE_N) - 1);
    localparam logic [3:0] UC_L   = 4'(UNIT_COUNT);
    localparam logic [4:0] OUTS_L = 5'(OUTS);

    pcst_pkg::cmd_t cmd_reg;
    logic [8:0]  code_reg;
    logic [7:0]  mask_reg;
    logic        en_reg;
    logic [15:0] ticks_reg;
    logic [15:0] default_period_reg;

    logic [15:0] unit_period_reg    [UNIT_COUNT];
    logic [15:0] output_width_reg   [OUTS];
    logic        output_enabled_reg [OUTS];

    logic [15:0] tk_reg;
    logic [15:0] q_reg;
    logic        sat_reg;

    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;
    logic        m_tlast_reg;

    logic [2:0]       code_hi;
    logic [2:0]       u_full;
    logic [2:0]       wsel;
    logic             width_ok;
    logic [OUT_W-1:0] sel_idx;
    logic             sel_in;
    logic [UIW-1:0]   unit_sel;
    logic [OUT_W-1:0] wen_idx;
    logic [15:0]      width_rd;
    logic [15:0]      period_rd;
    logic [15:0]      operand;
    logic [15:0]      limit;
    logic             use_limit;
    logic [15:0]      clamped;
    logic [22:0]      y_full;
    logic [37:0]      prod;
    logic [15:0]      scaled;
    logic [15:0]      emit_value;

    // Decode of the captured command
    assign code_hi  = code_reg[8:6];
    assign u_full   = (code_hi == 3'd0) ? 3'd0 : code_hi - 3'd1;
    assign width_ok = ({2'b00, wsel} < OUTS_L);
    assign wen_idx  = OUT_W'(wsel);

    always_comb begin
        wsel = 3'd0;
        for (int i = 1; i < 8; i++) begin
            if (mask_reg[i]) begin
                wsel = 3'(i);
            end
        end
    end

    // State reads at the controller-selected output
    assign sel_idx  = OUT_W'(cmd_i.sel);
    assign sel_in   = ({1'b0, cmd_i.sel} < OUTS_L);
    assign unit_sel = UIW'(sel_idx >> 1);
    assign width_rd  = sel_in ? output_width_reg[sel_idx] : 16'd0;
    assign period_rd = sel_in ? unit_period_reg[unit_sel] : 16'd0;

    always_comb begin
        case (cmd_i.src)
            pcst_pkg::SRC_DEFAULT: operand = default_period_reg;
            pcst_pkg::SRC_TICKS:   operand = ticks_reg;
            pcst_pkg::SRC_WIDTH:   operand = width_rd;
            default:               operand = period_rd;
        endcase
        case (cmd_i.lim)
            pcst_pkg::LIM_TICKS: begin
                limit     = ticks_reg;
                use_limit = 1'b1;
            end
            pcst_pkg::LIM_PERIOD: begin
                limit     = period_rd;
                use_limit = 1'b1;
            end
            default: begin
                limit     = 16'd0;
                use_limit = 1'b0;
            end
        endcase
        clamped = (use_limit && (operand > limit)) ? limit : operand;
    end

    // Scaler: 80*t+1, then divide by 3 through a reciprocal multiply
    assign y_full = 23'({tk_reg, 6'b0}) + 23'({tk_reg, 4'b0}) + 23'd1;
    assign prod   = 38'(y_full[17:0]) * 38'(pcst_pkg::SCALE_RECIP);
    assign scaled = sat_reg ? 16'hFFFF : q_reg;

    always_comb begin
        case (cmd_i.val)
            pcst_pkg::VAL_CTL: emit_value = pcst_pkg::CTL_INIT;
            pcst_pkg::VAL_ACT: emit_value = pcst_pkg::ACT_INIT;
            pcst_pkg::VAL_ZERO: emit_value = 16'd0;
            default:           emit_value = scaled;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd_i.latch) begin
            cmd_reg   <= pcst_pkg::cmd_t'(s_tuser);
            code_reg  <= s_tdata[8:0];
            mask_reg  <= s_tdata[16:9];
            en_reg    <= s_tdata[17];
            ticks_reg <= s_tdata[33:18];
        end
        if (cmd_i.load) begin
            tk_reg <= clamped;
        end
        if (cmd_i.mul) begin
            sat_reg <= (tk_reg > pcst_pkg::SCALE_SAT_TICKS);
            q_reg   <= prod[pcst_pkg::SCALE_SHIFT+15:pcst_pkg::SCALE_SHIFT];
        end
        if (cmd_i.emit) begin
            m_tdata_reg <= {1'b0, emit_value, cmd_i.offset, cmd_i.unit};
            m_tlast_reg <= cmd_i.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_period_reg <= pcst_pkg::PERIOD_RST;
            for (int u = 0; u < UNIT_COUNT; u++) begin
                unit_period_reg[u] <= pcst_pkg::PERIOD_RST;
            end
            for (int n = 0; n < OUTS; n++) begin
                output_width_reg[n]   <= pcst_pkg::PERIOD_RST;
                output_enabled_reg[n] <= 1'b0;
            end
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                default_period_reg <= cfg_wdata;
            end
            if (cmd_i.init_state) begin
                for (int u = 0; u < UNIT_COUNT; u++) begin
                    unit_period_reg[u] <= default_period_reg;
                end
                for (int n = 0; n < OUTS; n++) begin
                    output_width_reg[n]   <= default_period_reg;
                    output_enabled_reg[n] <= 1'b0;
                end
            end
            if (cmd_i.store_period) begin
                unit_period_reg[UIW'(u_full)] <= ticks_reg;
            end
            if (cmd_i.store_width) begin
                output_width_reg[sel_idx] <= clamped;
            end
            if (cmd_i.store_enable) begin
                output_enabled_reg[sel_idx] <= en_reg;
            end
            if (cmd_i.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign status_o.cmd           = cmd_reg;
    assign status_o.period_ok     = ({1'b0, u_full} < UC_L) && (ticks_reg != 16'd0);
    assign status_o.width_ok      = width_ok;
    assign status_o.width_sel     = wsel;
    assign status_o.width_enabled = width_ok ? output_enabled_reg[wen_idx] : 1'b0;
    assign status_o.gate_mask     = mask_reg & GATE_MASK;
    assign status_o.en            = en_reg;
    assign status_o.unit_full     = u_full;
    assign status_o.out_free      = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

`default_nettype wire

[hdl/pcst_ctrl.sv]
// Controller: sequences the register writes of each command.
`default_nettype none

module pcst_ctrl #(
    parameter int UNIT_COUNT = pcst_pkg::UNIT_COUNT_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire pcst_pkg::dp_status_t  status_i,
    output pcst_pkg::dp_cmd_t          cmd_o
);

    localparam int IDX_W = $clog2(8 * UNIT_COUNT);
    localparam logic [IDX_W-1:0] INIT_LAST = IDX_W'(8 * UNIT_COUNT - 1);

    pcst_pkg::state_t state_reg, state_next;
    logic [IDX_W-1:0] step_reg, step_next;
    logic [2:0]       pos_reg, pos_next;

    logic [7:0] gate_rest;
    logic       gate_hit;
    logic       gate_more;
    logic       write_last;

    assign gate_rest = status_i.gate_mask >> pos_reg;
    assign gate_hit  = gate_rest[0];
    assign gate_more = |gate_rest[7:1];

    always_comb begin
        case (status_i.cmd)
            pcst_pkg::CMD_INIT:   write_last = (step_reg == INIT_LAST);
            pcst_pkg::CMD_PERIOD: write_last = (pos_reg == 3'd2);
            pcst_pkg::CMD_GATE:   write_last = !gate_more;
            default:              write_last = 1'b1;
        endcase
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        pos_next   = pos_reg;
        unique case (state_reg)
            pcst_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = pcst_pkg::ST_DECODE;
                end
            end
            pcst_pkg::ST_DECODE: begin
                step_next = '0;
                pos_next  = 3'd0;
                unique case (status_i.cmd)
                    pcst_pkg::CMD_INIT: state_next = pcst_pkg::ST_LOAD;
                    pcst_pkg::CMD_PERIOD: begin
                        state_next = status_i.period_ok ? pcst_pkg::ST_LOAD
                                                        : pcst_pkg::ST_IDLE;
                    end
                    pcst_pkg::CMD_GATE: begin
                        state_next = (status_i.gate_mask != 8'd0) ? pcst_pkg::ST_GATE_SCAN
                                                                  : pcst_pkg::ST_IDLE;
                    end
                    default: begin
                        state_next = (status_i.width_ok && status_i.width_enabled)
                                   ? pcst_pkg::ST_LOAD : pcst_pkg::ST_IDLE;
                    end
                endcase
            end
            pcst_pkg::ST_GATE_SCAN: begin
                if (gate_hit) begin
                    state_next = pcst_pkg::ST_LOAD;
                end else begin
                    pos_next = pos_reg + 3'd1;
                end
            end
            pcst_pkg::ST_LOAD: state_next = pcst_pkg::ST_MUL;
            pcst_pkg::ST_MUL: begin
                state_next = (status_i.cmd == pcst_pkg::CMD_INIT) ? pcst_pkg::ST_INIT_EMIT
                                                                  : pcst_pkg::ST_EMIT;
            end
            pcst_pkg::ST_EMIT: begin
                if (status_i.out_free) begin
                    if (write_last) begin
                        state_next = pcst_pkg::ST_IDLE;
                    end else begin
                        pos_next   = pos_reg + 3'd1;
                        state_next = (status_i.cmd == pcst_pkg::CMD_GATE)
                                   ? pcst_pkg::ST_GATE_SCAN : pcst_pkg::ST_LOAD;
                    end
                end
            end
            pcst_pkg::ST_INIT_EMIT: begin
                if (status_i.out_free) begin
                    if (write_last) begin
                        state_next = pcst_pkg::ST_IDLE;
                    end else begin
                        step_next = step_reg + IDX_W'(1);
                    end
                end
            end
            default: state_next = pcst_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd_o          = '0;
        cmd_o.src      = pcst_pkg::SRC_TICKS;
        cmd_o.lim      = pcst_pkg::LIM_NONE;
        cmd_o.val      = pcst_pkg::VAL_SCALED;
        cmd_o.last     = write_last;
        s_tready       = 1'b0;

        case (status_i.cmd)
            pcst_pkg::CMD_INIT: begin
                cmd_o.src    = pcst_pkg::SRC_DEFAULT;
                cmd_o.val    = pcst_pkg::init_value(step_reg[2:0]);
                cmd_o.offset = pcst_pkg::init_offset(step_reg[2:0]);
                cmd_o.unit   = 2'(step_reg >> 3);
            end
            pcst_pkg::CMD_PERIOD: begin
                cmd_o.unit = status_i.unit_full[1:0];
                cmd_o.sel  = {status_i.unit_full, pos_reg == 3'd2};
                if (pos_reg == 3'd0) begin
                    cmd_o.offset = pcst_pkg::OFF_PRD;
                end else begin
                    cmd_o.src    = pcst_pkg::SRC_WIDTH;
                    cmd_o.lim    = pcst_pkg::LIM_TICKS;
                    cmd_o.offset = (pos_reg == 3'd2) ? pcst_pkg::OFF_CMPB : pcst_pkg::OFF_CMPA;
                end
            end
            pcst_pkg::CMD_GATE: begin
                cmd_o.src    = status_i.en ? pcst_pkg::SRC_WIDTH : pcst_pkg::SRC_PERIOD;
                cmd_o.lim    = pcst_pkg::LIM_PERIOD;
                cmd_o.sel    = {1'b0, pos_reg};
                cmd_o.unit   = pos_reg[2:1];
                cmd_o.offset = pos_reg[0] ? pcst_pkg::OFF_CMPB : pcst_pkg::OFF_CMPA;
            end
            default: begin
                cmd_o.lim    = pcst_pkg::LIM_PERIOD;
                cmd_o.sel    = {1'b0, status_i.width_sel};
                cmd_o.unit   = status_i.width_sel[2:1];
                cmd_o.offset = status_i.width_sel[0] ? pcst_pkg::OFF_CMPB : pcst_pkg::OFF_CMPA;
            end
        endcase

        unique case (state_reg)
            pcst_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd_o.latch = s_tvalid;
            end
            pcst_pkg::ST_DECODE: begin
                cmd_o.store_period = (status_i.cmd == pcst_pkg::CMD_PERIOD)
                                   && status_i.period_ok;
                cmd_o.store_width  = (status_i.cmd == pcst_pkg::CMD_WIDTH)
                                   && status_i.width_ok;
            end
            pcst_pkg::ST_LOAD: begin
                cmd_o.load         = 1'b1;
                cmd_o.store_enable = (status_i.cmd == pcst_pkg::CMD_GATE);
            end
            pcst_pkg::ST_MUL: cmd_o.mul = 1'b1;
            pcst_pkg::ST_EMIT: cmd_o.emit = status_i.out_free;
            pcst_pkg::ST_INIT_EMIT: begin
                cmd_o.emit       = status_i.out_free;
                cmd_o.init_state = status_i.out_free && write_last;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pcst_pkg::ST_IDLE;
            step_reg  <= '0;
            pos_reg   <= 3'd0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            pos_reg   <= pos_next;
        end
    end

    a_emit_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_o.emit |-> status_i.out_free)
        else $error("write issued while output register is occupied");

    a_last_ends_command: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd_o.emit && cmd_o.last) |=> (state_reg == pcst_pkg::ST_IDLE))
        else $error("controller did not return to idle after final write");

    a_init_step_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pcst_pkg::ST_INIT_EMIT) |-> (step_reg <= INIT_LAST))
        else $error("init write counter ran past the last unit");

    a_scan_has_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pcst_pkg::ST_GATE_SCAN) |-> (gate_rest != 8'd0))
        else $error("gate scan entered with no output left to write");

endmodule

`default_nettype wire

[hdl/pwm_compare_shadow_translator_unit.sv]
// Top level of the PWM compare shadow translator: controller plus datapath.
//
// Usage:
//   Slave channel (s_*) takes one legacy PWM command per transaction: init,
//   period set, output gate or pulse width set. Master channel (m_*) returns
//   the register writes that command causes, one per transaction, with
//   m_tlast high on the final write of the command. A command that causes no
//   write (bad unit, zero period, empty gate, disabled output) returns nothing.
//   cfg_we/cfg_wdata load the default period used by init; write it only while
//   the block is idle.
// Timing:
//   One command is processed at a time; s_tready is high only when the block
//   is idle. Every tick value passes through one shared scaler (one multiply
//   stage), so each period, width or gate write takes load, multiply and emit
//   steps; a gate write also takes a scan step, plus one per skipped mask bit.
//   Init computes the scaled period once, then makes one write per cycle while
//   the output is not stalled.
// Reset: aresetn (synchronous, active low) restores all cached periods and
//   widths to 375 ticks, clears the enables and drops any pending output.
// Stall: when m_tready is low the single output register holds its
//   transaction and the controller waits; nothing is lost or repeated.
`default_nettype none

module pwm_compare_shadow_translator_unit #(
    parameter int UNIT_COUNT = pcst_pkg::UNIT_COUNT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration: default period in legacy ticks
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    // Command input
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [8:0] generator_code, [16:9] output_mask, [17] enable_flag,
    // [33:18] tick_value, [39:34] zero
    input  wire logic [39:0] s_tdata,
    // [1:0] command
    input  wire logic [1:0]  s_tuser,
    // Register write output
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [1:0] unit_index, [6:2] reg_offset, [22:7] reg_value, [23] zero
    output logic [23:0]      m_tdata,
    // last_write
    output logic             m_tlast
);

    // Command and status between controller and datapath
    pcst_pkg::dp_cmd_t    dp_cmd;
    pcst_pkg::dp_status_t dp_status;

    // Sequence each command's writes
    pcst_ctrl #(
        .UNIT_COUNT (UNIT_COUNT)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status_i (dp_status),
        .cmd_o    (dp_cmd)
    );

    // Hold cached state, clamp and scale ticks, drive the output register
    pcst_datapath #(
        .UNIT_COUNT (UNIT_COUNT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd_i     (dp_cmd),
        .status_o  (dp_status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
